>>> sv/wrmc_pkg.sv
// Shared types, widths and constants of the window rate mood classifier.
package wrmc_pkg;

    localparam int RING_DEPTH = 6;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 14;
    localparam int MOOD_W   = 2;
    localparam int HELD_W   = 3;
    localparam int MIN_W    = 16;
    localparam int LHS_W    = LEVEL_W + MIN_W;
    localparam int PROD_W   = TIME_W + LEVEL_W;

    localparam int S_TDATA_W = ((TIME_W + LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((MOOD_W + 1 + HELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // milliseconds per minute
    localparam logic [MIN_W-1:0] MS_PER_MIN = MIN_W'(60000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_NORMAL = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_ACTIVE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HEAVY  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RESET_DROP    = CFG_IDX_W'(4);

    localparam logic [TIME_W-1:0]  MIN_WINDOW_RST    = TIME_W'(240000);
    localparam logic [LEVEL_W-1:0] THRESH_NORMAL_RST = LEVEL_W'(10);
    localparam logic [LEVEL_W-1:0] THRESH_ACTIVE_RST = LEVEL_W'(20);
    localparam logic [LEVEL_W-1:0] THRESH_HEAVY_RST  = LEVEL_W'(33);
    localparam logic [LEVEL_W-1:0] RESET_DROP_RST    = LEVEL_W'(500);

    localparam logic [MOOD_W-1:0] MOOD_IDLE   = MOOD_W'(0);
    localparam logic [MOOD_W-1:0] MOOD_NORMAL = MOOD_W'(1);
    localparam logic [MOOD_W-1:0] MOOD_ACTIVE = MOOD_W'(2);
    localparam logic [MOOD_W-1:0] MOOD_HEAVY  = MOOD_W'(3);

    typedef struct packed {
        logic [TIME_W-1:0]  span_floor_ms;
        logic [LEVEL_W-1:0] thresh_normal;
        logic [LEVEL_W-1:0] thresh_active;
        logic [LEVEL_W-1:0] thresh_heavy;
        logic [LEVEL_W-1:0] reset_drop;
    } cfg_t;

    // window summary handed from the history stage to the rate stage
    typedef struct packed {
        logic               cleared;
        logic [FILL_W-1:0]  fill;
        logic               few;
        logic [TIME_W-1:0]  dt;
        logic [LEVEL_W-1:0] dp;
    } hist_t;

endpackage

>>> sv/window_rate_mood_classifier.sv
// Top level of the window rate mood classifier: ports, configuration registers, input register.
//
// Usage
//   Slave channel s_*: one utilisation sample per transfer (timestamp in ms,
//   level in 0.01 % units). Master channel m_*: one result per sample, in order.
//   Config port: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle;
//   change registers only while no sample is in flight.
// Timing
//   Four register stages: input register, history/window stage, product stage,
//   result register; each sample passes through them in that order.
//   One sample per cycle is sustained while m_tready stays high: every stage
//   does its share of the work and hands on as the next stage takes the previous item.
// Reset
//   aresetn (synchronous, active low) empties the history, drops any item in
//   flight and restores the register defaults. History payload is not cleared.
// Back-pressure
//   Each stage stalls only when the stage after it is full, so bubbles are
//   squeezed out; with m_tready low the pipe fills and s_tready falls after
//   four items are held.
module window_rate_mood_classifier (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wrmc_pkg::S_TDATA_W-1:0]    s_tdata,   // time_ms[31:0], usage_level[45:32]
    // master channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wrmc_pkg::M_TDATA_W-1:0]    m_tdata,   // mood[1:0], history_cleared[2],
                                                         // samples_held[5:3]
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [wrmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wrmc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wrmc_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               h_in_ready;

    logic               hist_valid;
    logic               hist_ready;
    hist_t              hist;

    logic [MOOD_W-1:0]        out_mood;
    logic                     out_cleared;
    logic [FILL_W-1:0]        out_fill;
    logic [FILL_W+HELD_W-1:0] fill_ext;
    logic [HELD_W-1:0]        samples_held;

    // configuration registers; out-of-range indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.span_floor_ms <= MIN_WINDOW_RST;
            cfg_reg.thresh_normal <= THRESH_NORMAL_RST;
            cfg_reg.thresh_active <= THRESH_ACTIVE_RST;
            cfg_reg.thresh_heavy  <= THRESH_HEAVY_RST;
            cfg_reg.reset_drop    <= RESET_DROP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_WINDOW:    cfg_reg.span_floor_ms <= cfg_wdata[TIME_W-1:0];
                REG_THRESH_NORMAL: cfg_reg.thresh_normal <= cfg_wdata[LEVEL_W-1:0];
                REG_THRESH_ACTIVE: cfg_reg.thresh_active <= cfg_wdata[LEVEL_W-1:0];
                REG_THRESH_HEAVY:  cfg_reg.thresh_heavy  <= cfg_wdata[LEVEL_W-1:0];
                REG_RESET_DROP:    cfg_reg.reset_drop    <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign s_tready = !in_valid_reg || h_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_time_reg  <= s_tdata[TIME_W-1:0];
            in_level_reg <= s_tdata[TIME_W+LEVEL_W-1:TIME_W];
        end
    end

    wrmc_history u_history (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_ready   (h_in_ready),
        .in_time    (in_time_reg),
        .in_level   (in_level_reg),
        .reset_drop (cfg_reg.reset_drop),
        .hist_valid (hist_valid),
        .hist_ready (hist_ready),
        .hist       (hist)
    );

    wrmc_rate u_rate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .hist_valid  (hist_valid),
        .hist_ready  (hist_ready),
        .hist        (hist),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_mood    (out_mood),
        .out_cleared (out_cleared),
        .out_fill    (out_fill)
    );

    // sample count is reported in a fixed 3-bit field
    assign fill_ext     = {{HELD_W{1'b0}}, out_fill};
    assign samples_held = fill_ext[HELD_W-1:0];
    assign m_tdata      = M_TDATA_W'({samples_held, out_cleared, out_mood});

endmodule

>>> sv/wrmc_history.sv
// Sample history shift line, drop detection and window span/rise.
module wrmc_history (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wrmc_pkg::TIME_W-1:0]  in_time,
    input  logic [wrmc_pkg::LEVEL_W-1:0] in_level,
    input  logic [wrmc_pkg::LEVEL_W-1:0] reset_drop,
    output logic                         hist_valid,
    input  logic                         hist_ready,
    output wrmc_pkg::hist_t              hist
);
    import wrmc_pkg::*;

    // tap 0 is the newest sample
    logic [TIME_W-1:0]  tap_time_reg  [RING_DEPTH];
    logic [LEVEL_W-1:0] tap_level_reg [RING_DEPTH];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               valid_reg;
    hist_t              hist_reg, hist_next;
    logic               fire;
    logic               clear;
    logic [FILL_W-1:0]  old_pos;
    logic [IDX_W-1:0]   old_idx;
    logic [TIME_W-1:0]  old_time;
    logic [LEVEL_W-1:0] old_level;

    assign in_ready   = !valid_reg || hist_ready;
    assign fire       = in_valid && in_ready;
    assign hist_valid = valid_reg;
    assign hist       = hist_reg;

    always_comb begin
        clear = (fill_reg != '0) &&
                (({1'b0, in_level} + {1'b0, reset_drop}) < {1'b0, tap_level_reg[0]});
        if (clear) begin
            fill_next = FILL_W'(1);
        end else if (fill_reg == FILL_W'(RING_DEPTH)) begin
            fill_next = fill_reg;
        end else begin
            fill_next = fill_reg + FILL_W'(1);
        end
        // oldest after the shift sits one tap lower before it
        old_pos   = fill_next - FILL_W'(2);
        old_idx   = old_pos[IDX_W-1:0];
        old_time  = tap_time_reg[old_idx];
        old_level = tap_level_reg[old_idx];

        hist_next.cleared = clear;
        hist_next.fill    = fill_next;
        hist_next.few     = fill_next < FILL_W'(2);
        hist_next.dt      = in_time - old_time;
        hist_next.dp      = (in_level > old_level) ? (in_level - old_level) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            fill_reg  <= '0;
        end else begin
            if (in_ready) valid_reg <= in_valid;
            if (fire) fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            hist_reg         <= hist_next;
            tap_time_reg[0]  <= in_time;
            tap_level_reg[0] <= in_level;
            for (int i = 1; i < RING_DEPTH; i++) begin
                tap_time_reg[i]  <= tap_time_reg[i-1];
                tap_level_reg[i] <= tap_level_reg[i-1];
            end
        end
    end

endmodule

>>> sv/wrmc_rate.sv
// Cross-multiplied rate products and threshold binning into the result register.
module wrmc_rate (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wrmc_pkg::cfg_t               cfg,
    input  logic                         hist_valid,
    output logic                         hist_ready,
    input  wrmc_pkg::hist_t              hist,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wrmc_pkg::MOOD_W-1:0]  out_mood,
    output logic                         out_cleared,
    output logic [wrmc_pkg::FILL_W-1:0]  out_fill
);
    import wrmc_pkg::*;

    // product stage
    logic               pv_reg;
    logic               p_short_reg;
    logic               p_cleared_reg;
    logic [FILL_W-1:0]  p_fill_reg;
    logic [LHS_W-1:0]   lhs_reg,  lhs_next;
    logic [PROD_W-1:0]  pn_reg,   pn_next;
    logic [PROD_W-1:0]  pa_reg,   pa_next;
    logic [PROD_W-1:0]  ph_reg,   ph_next;
    logic               p_ready;

    // result stage
    logic               ov_reg;
    logic [MOOD_W-1:0]  mood_reg, mood_next;
    logic               cleared_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [PROD_W-1:0]  lhs_ext;

    assign p_ready    = !ov_reg || out_ready;
    assign hist_ready = !pv_reg || p_ready;

    assign lhs_next = LHS_W'(hist.dp) * LHS_W'(MS_PER_MIN);
    assign pn_next  = PROD_W'(cfg.thresh_normal) * PROD_W'(hist.dt);
    assign pa_next  = PROD_W'(cfg.thresh_active) * PROD_W'(hist.dt);
    assign ph_next  = PROD_W'(cfg.thresh_heavy)  * PROD_W'(hist.dt);

    always_comb begin
        lhs_ext = PROD_W'(lhs_reg);
        if (p_short_reg) begin
            mood_next = MOOD_IDLE;
        end else if (lhs_ext < pn_reg) begin
            mood_next = MOOD_IDLE;
        end else if (lhs_ext < pa_reg) begin
            mood_next = MOOD_NORMAL;
        end else if (lhs_ext < ph_reg) begin
            mood_next = MOOD_ACTIVE;
        end else begin
            mood_next = MOOD_HEAVY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (hist_ready) pv_reg <= hist_valid;
            if (p_ready)    ov_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_valid && hist_ready) begin
            p_short_reg   <= hist.few || (hist.dt < cfg.span_floor_ms);
            p_cleared_reg <= hist.cleared;
            p_fill_reg    <= hist.fill;
            lhs_reg       <= lhs_next;
            pn_reg        <= pn_next;
            pa_reg        <= pa_next;
            ph_reg        <= ph_next;
        end
        if (pv_reg && p_ready) begin
            mood_reg    <= mood_next;
            cleared_reg <= p_cleared_reg;
            fill_reg    <= p_fill_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign out_mood    = mood_reg;
    assign out_cleared = cleared_reg;
    assign out_fill    = fill_reg;

endmodule
